@@ rtl/yuvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Types, coefficients and helpers shared by the pixel-pair color converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

  localparam logic [7:0]  LUMA_BLACK     = 8'd16;
  localparam logic [7:0]  CHROMA_ZERO    = 8'd128;

  // limited range, 10 fractional bits
  localparam logic [10:0] LUMA_COEF_LIM  = 11'd1192;
  localparam logic [16:0] CR_COEF_LIM    = 17'd1634;
  localparam logic [16:0] CGV_COEF_LIM   = 17'd833;
  localparam logic [16:0] CGU_COEF_LIM   = 17'd400;
  localparam logic [16:0] CB_COEF_LIM    = 17'd2066;

  // full range, Q16
  localparam logic [16:0] CR_COEF_FULL   = 17'd91881;
  localparam logic [16:0] CGU_COEF_FULL  = 17'd22554;
  localparam logic [16:0] CGV_COEF_FULL  = 17'd46802;
  localparam logic [16:0] CB_COEF_FULL   = 17'd116130;

  localparam logic        MODE_LIMITED   = 1'b0;
  localparam logic        MODE_FULL      = 1'b1;

  localparam int unsigned SHIFT_LIMITED  = 10;
  localparam int unsigned SHIFT_FULL     = 16;

  // stage 1: offsets removed
  typedef struct packed {
    logic              mode;
    logic signed [8:0] ud;
    logic signed [8:0] vd;
    logic [7:0]        luma0;
    logic [7:0]        luma1;
  } front_t;

  // stage 2: products
  typedef struct packed {
    logic               mode;
    logic [23:0]        lum0;
    logic [23:0]        lum1;
    logic signed [25:0] cr;
    logic signed [25:0] cgu;
    logic signed [25:0] cgv;
    logic signed [25:0] cb;
  } prod_t;

  // load enables of the sum and saturate stages
  typedef struct packed {
    logic en_sum;
    logic en_sat;
  } sat_ctl_t;

  function automatic logic [16:0] pick_coef(logic mode, logic [16:0] lim, logic [16:0] full);
    return (mode == MODE_FULL) ? full : lim;
  endfunction

  // floor at zero, scale down, saturate at 255
  function automatic logic [7:0] sat8(logic signed [26:0] v, logic mode);
    logic [26:0] u;
    logic [26:0] sh;
    u  = v;
    sh = (mode == MODE_FULL) ? (u >> SHIFT_FULL) : (u >> SHIFT_LIMITED);
    if (v < 0) begin
      return 8'd0;
    end else if (sh > 27'd255) begin
      return 8'd255;
    end
    return sh[7:0];
  endfunction

endpackage

@@ rtl/yuvrgb_mul.sv @@
// ----------------------------------------------------------------------------
// yuvrgb_mul
// Product stage: luma and chroma terms for both pixels of the pair.
// ----------------------------------------------------------------------------
module yuvrgb_mul
  import yuvrgb_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  front_t front,
  output prod_t  prod_r
);

  prod_t              prod_nxt;
  logic [18:0]        lim0;
  logic [18:0]        lim1;
  logic signed [26:0] cr_full;
  logic signed [26:0] cgu_full;
  logic signed [26:0] cgv_full;
  logic signed [26:0] cb_full;

  always_comb begin
    lim0     = 19'(front.luma0) * 19'(LUMA_COEF_LIM);
    lim1     = 19'(front.luma1) * 19'(LUMA_COEF_LIM);
    cr_full  = front.vd * $signed({1'b0, pick_coef(front.mode, CR_COEF_LIM, CR_COEF_FULL)});
    cgu_full = front.ud * $signed({1'b0, pick_coef(front.mode, CGU_COEF_LIM, CGU_COEF_FULL)});
    cgv_full = front.vd * $signed({1'b0, pick_coef(front.mode, CGV_COEF_LIM, CGV_COEF_FULL)});
    cb_full  = front.ud * $signed({1'b0, pick_coef(front.mode, CB_COEF_LIM, CB_COEF_FULL)});

    prod_nxt.mode = front.mode;
    // full range: luma times one in Q16 is a plain shift
    prod_nxt.lum0 = (front.mode == MODE_FULL) ? {front.luma0, 16'd0} : {5'd0, lim0};
    prod_nxt.lum1 = (front.mode == MODE_FULL) ? {front.luma1, 16'd0} : {5'd0, lim1};
    prod_nxt.cr   = cr_full[25:0];
    prod_nxt.cgu  = cgu_full[25:0];
    prod_nxt.cgv  = cgv_full[25:0];
    prod_nxt.cb   = cb_full[25:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ rtl/yuvrgb_sat.sv @@
// ----------------------------------------------------------------------------
// yuvrgb_sat
// Sum and saturate stages for one pixel: three channel sums, then 8-bit RGB.
// ----------------------------------------------------------------------------
module yuvrgb_sat
  import yuvrgb_pkg::*;
(
  input  logic               clk,
  input  sat_ctl_t           ctl,
  input  logic               mode,
  input  logic [23:0]        lum,
  input  logic signed [25:0] cr,
  input  logic signed [25:0] cgu,
  input  logic signed [25:0] cgv,
  input  logic signed [25:0] cb,
  output logic [23:0]        rgb_r      // red [7:0], green [15:8], blue [23:16]
);

  logic signed [26:0] lum_s;
  logic signed [26:0] r_sum_nxt, g_sum_nxt, b_sum_nxt;
  logic signed [26:0] r_sum_r, g_sum_r, b_sum_r;
  logic               mode_r;
  logic [23:0]        rgb_nxt;

  always_comb begin
    lum_s     = $signed({3'b000, lum});
    r_sum_nxt = lum_s + $signed({cr[25], cr});
    g_sum_nxt = lum_s - $signed({cgu[25], cgu}) - $signed({cgv[25], cgv});
    b_sum_nxt = lum_s + $signed({cb[25], cb});
    rgb_nxt   = {sat8(b_sum_r, mode_r), sat8(g_sum_r, mode_r), sat8(r_sum_r, mode_r)};
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      r_sum_r <= r_sum_nxt;
      g_sum_r <= g_sum_nxt;
      b_sum_r <= b_sum_nxt;
      mode_r  <= mode;
    end
    if (ctl.en_sat) begin
      rgb_r <= rgb_nxt;
    end
  end

endmodule

@@ rtl/yuv_pair_to_rgb_converter.sv @@
// Throughput: one pixel pair per cycle while the output side is not stalled;
// register stages are offset removal, products, channel sums and saturation,
// each with its own valid bit. A stall holds each full stage behind it while
// empty stages still advance, so bubbles are squeezed out.
// Reset (synchronous, rst_n low) clears all valid bits and sets the mode to
// limited range.
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_converter
// BT.601 conversion of a luma pair with shared chroma into two RGB pixels.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb_converter
  import yuvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // conversion_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // luma_first, luma_second, chroma_blue, chroma_red
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata      // red_first, green_first, blue_first,
                                     // red_second, green_second, blue_second
);

  logic       mode_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic       adv1, adv2, adv3, adv4;
  front_t     front_nxt, front_r;
  prod_t      prod_r;
  sat_ctl_t   sat_ctl;
  logic [7:0] y0, y1, cb_in, cr_in;
  logic [23:0] rgb0_r, rgb1_r;

  // a stage moves when it is empty or the one after it moves
  assign adv4      = out_tready | ~v4_r;
  assign adv3      = adv4 | ~v3_r;
  assign adv2      = adv3 | ~v2_r;
  assign adv1      = adv2 | ~v1_r;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIMITED;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  assign y0    = in_tdata[7:0];
  assign y1    = in_tdata[15:8];
  assign cb_in = in_tdata[23:16];
  assign cr_in = in_tdata[31:24];

  always_comb begin
    front_nxt.mode = mode_r;
    front_nxt.ud   = $signed({1'b0, cb_in}) - $signed({1'b0, CHROMA_ZERO});
    front_nxt.vd   = $signed({1'b0, cr_in}) - $signed({1'b0, CHROMA_ZERO});
    if (mode_r == MODE_FULL) begin
      front_nxt.luma0 = y0;
      front_nxt.luma1 = y1;
    end else begin
      // floor dark luma at black level
      front_nxt.luma0 = (y0 < LUMA_BLACK) ? 8'd0 : (y0 - LUMA_BLACK);
      front_nxt.luma1 = (y1 < LUMA_BLACK) ? 8'd0 : (y1 - LUMA_BLACK);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      front_r <= front_nxt;
    end
  end

  yuvrgb_mul u_mul (
    .clk    (clk),
    .en     (adv2),
    .front  (front_r),
    .prod_r (prod_r)
  );

  assign sat_ctl.en_sum = adv3;
  assign sat_ctl.en_sat = adv4;

  yuvrgb_sat u_sat0 (
    .clk   (clk),
    .ctl   (sat_ctl),
    .mode  (prod_r.mode),
    .lum   (prod_r.lum0),
    .cr    (prod_r.cr),
    .cgu   (prod_r.cgu),
    .cgv   (prod_r.cgv),
    .cb    (prod_r.cb),
    .rgb_r (rgb0_r)
  );

  yuvrgb_sat u_sat1 (
    .clk   (clk),
    .ctl   (sat_ctl),
    .mode  (prod_r.mode),
    .lum   (prod_r.lum1),
    .cr    (prod_r.cr),
    .cgu   (prod_r.cgu),
    .cgv   (prod_r.cgv),
    .cb    (prod_r.cb),
    .rgb_r (rgb1_r)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {rgb1_r, rgb0_r};

endmodule

@@ rtl/yuvrgb_chk.sv @@
// ----------------------------------------------------------------------------
// yuvrgb_chk
// Port-level checks on the converter pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module yuvrgb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  // an accepted word reaches the output stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##4 out_tvalid)
    else $error("accepted word did not reach the output");

  // a free output side never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

endmodule

bind yuv_pair_to_rgb_converter yuvrgb_chk u_yuvrgb_chk (.*);

@@ dv/yuv_pair_to_rgb_converter_chk.sv @@
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_converter_chk
// Passive checker for the pixel-pair color converter. It follows the mode
// register and the input handshakes, and computes the RGB pair for every
// accepted word. It then compares each accepted output word, channel by
// channel, with the oldest pending pair.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb_converter_chk
  import yuvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // conversion_mode
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,      // luma_first, luma_second, chroma_blue, chroma_red
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,     // red_first, green_first, blue_first,
                                     // red_second, green_second, blue_second
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint K_LUMA_LIM = 1192;
  localparam longint K_RV_LIM   = 1634;
  localparam longint K_GV_LIM   = 833;
  localparam longint K_GU_LIM   = 400;
  localparam longint K_BU_LIM   = 2066;
  localparam longint MAX_LIM    = 262143;
  localparam longint K_RV_FULL  = 91881;
  localparam longint K_GU_FULL  = 22554;
  localparam longint K_GV_FULL  = 46802;
  localparam longint K_BU_FULL  = 116130;

  // last field sits in the lowest bits
  typedef struct packed {
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] luma_first;
  } yuv_pair_t;

  typedef struct packed {
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
  } rgb_pair_t;

  logic      conv_mode;
  rgb_pair_t pending_pairs[$];
  int        errors;

  function automatic logic [7:0] limited_channel(longint v);
    if (v < 0) v = 0;
    if (v > MAX_LIM) v = MAX_LIM;
    return 8'(v >>> 10);
  endfunction

  function automatic logic [7:0] full_channel(longint v);
    if (v < 0) return 8'd0;
    v = v >>> 16;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // returns {blue, green, red}
  function automatic logic [23:0] pixel_rgb(logic mode, logic [7:0] luma, longint ud, longint vd);
    longint     yd;
    longint     ys;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    if (mode == MODE_LIMITED) begin
      // dark luma counts as black
      yd = longint'(luma) - 16;
      if (yd < 0) yd = 0;
      r = limited_channel(K_LUMA_LIM * yd + K_RV_LIM * vd);
      g = limited_channel(K_LUMA_LIM * yd - K_GV_LIM * vd - K_GU_LIM * ud);
      b = limited_channel(K_LUMA_LIM * yd + K_BU_LIM * ud);
    end else begin
      ys = longint'(luma) * 65536;
      r = full_channel(ys + K_RV_FULL * vd);
      g = full_channel(ys - K_GU_FULL * ud - K_GV_FULL * vd);
      b = full_channel(ys + K_BU_FULL * ud);
    end
    return {b, g, r};
  endfunction

  function automatic rgb_pair_t convert_pair(logic mode, yuv_pair_t w);
    longint    ud;
    longint    vd;
    rgb_pair_t p;
    ud = longint'(w.chroma_blue) - 128;
    vd = longint'(w.chroma_red) - 128;
    {p.blue_first, p.green_first, p.red_first}    = pixel_rgb(mode, w.luma_first, ud, vd);
    {p.blue_second, p.green_second, p.red_second} = pixel_rgb(mode, w.luma_second, ud, vd);
    return p;
  endfunction

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors     = 0;
    conv_mode  = MODE_LIMITED;
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    rgb_pair_t want;
    rgb_pair_t got;
    if (!rst_n) begin
      pending_pairs.delete();
      conv_mode = MODE_LIMITED;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_pairs.size() == 0) begin
          $error("output word %h with no pending pair", out_tdata);
          errors++;
        end else begin
          want = pending_pairs.pop_front();
          check_channel("red_first", want.red_first, got.red_first);
          check_channel("green_first", want.green_first, got.green_first);
          check_channel("blue_first", want.blue_first, got.blue_first);
          check_channel("red_second", want.red_second, got.red_second);
          check_channel("green_second", want.green_second, got.green_second);
          check_channel("blue_second", want.blue_second, got.blue_second);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_pairs.insert(pending_pairs.size(), convert_pair(conv_mode, in_tdata));
      end
      if (cfg_wr_en) begin
        conv_mode = cfg_wr_data;
      end
    end
    fail_count <= errors;
    pending    <= pending_pairs.size();
  end

endmodule

@@ dv/yuv_pair_to_rgb_converter_tb.sv @@
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_converter_tb
// Stimulus for the pixel-pair color converter. It sends directed corner words
// in both modes, then random pairs in several mode phases. Both sides idle at
// random, and the output side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module yuv_pair_to_rgb_converter_tb
  import yuvrgb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 200;
  localparam int PHASE_WORDS  = 350;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  int          fail_count;
  int          pending;
  bit          hold_output;

  // {chroma_red, chroma_blue, luma_second, luma_first}
  logic [31:0] corner_words [12] = '{
    {8'd128, 8'd128, 8'd0,   8'd0},
    {8'd128, 8'd128, 8'd255, 8'd255},
    {8'd128, 8'd128, 8'd16,  8'd15},
    {8'd128, 8'd128, 8'd17,  8'd235},
    {8'd0,   8'd0,   8'd0,   8'd255},
    {8'd255, 8'd255, 8'd255, 8'd0},
    {8'd255, 8'd0,   8'd128, 8'd128},
    {8'd0,   8'd255, 8'd128, 8'd128},
    {8'd255, 8'd255, 8'd255, 8'd255},
    {8'd0,   8'd0,   8'd0,   8'd0},
    {8'd127, 8'd129, 8'd1,   8'd254},
    {8'd200, 8'd50,  8'd100, 8'd180}
  };

  yuv_pair_to_rgb_converter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  yuv_pair_to_rgb_converter_chk i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_500_000;
    $display("yuv_pair_to_rgb_converter: mismatch");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [12] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127,
                                 8'd128, 8'd129, 8'd235, 8'd240, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold the word until accepted, then idle for the given gap
  task automatic send_pair(logic [31:0] word, int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic mode);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_corners();
    foreach (corner_words[i]) send_pair(corner_words[i], next_gap());
    in_tvalid <= 1'b0;
  endtask

  task automatic send_random(int count, bit back_to_back);
    for (int i = 0; i < count; i++) begin
      send_pair({pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                back_to_back ? 0 : next_gap());
    end
    in_tvalid <= 1'b0;
  endtask

  // output side: random ready pattern, plus one long hold on request
  initial begin
    int r;
    int run;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_tready <= 1'b1;
          run = $urandom_range(50, 150);
        end else if (r < 65) begin
          out_tready <= 1'b1;
          run = $urandom_range(1, 6);
        end else if (r < 93) begin
          out_tready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    hold_output = 1'b0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= MODE_LIMITED;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners in the reset mode, then in full range
    send_corners();
    set_mode(MODE_FULL);
    send_corners();

    // back up the pipe: output held off while words keep coming
    set_mode(MODE_LIMITED);
    hold_output = 1'b1;
    send_random(PHASE_WORDS, 1'b1);

    set_mode(MODE_FULL);
    send_random(PHASE_WORDS, 1'b0);
    set_mode(MODE_LIMITED);
    send_random(PHASE_WORDS, 1'b1);
    set_mode(MODE_FULL);
    send_random(PHASE_WORDS, 1'b0);
    set_mode(MODE_FULL);
    send_random(PHASE_WORDS, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("yuv_pair_to_rgb_converter: match");
    end else begin
      $display("yuv_pair_to_rgb_converter: mismatch");
    end
    $finish;
  end

endmodule
